FILE: hdl/payload_signature_matcher_macros.svh
// Assertion macros for the signature matcher RTL.
`ifndef PAYLOAD_SIGNATURE_MATCHER_MACROS_SVH
`define PAYLOAD_SIGNATURE_MATCHER_MACROS_SVH

`ifndef SYNTHESIS
// Check a property on every clock edge outside reset.
`define PSM_ASSERT(name, prop) \
  name: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error("psm: assertion failed");
// Check that a condition is followed by an expected value in the next cycle.
`define PSM_ASSERT_NEXT(name, cond, expct) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (cond) |=> (expct)) \
    else $error("psm: assertion failed");
`else
`define PSM_ASSERT(name, prop)
`define PSM_ASSERT_NEXT(name, cond, expct)
`endif

`endif

FILE: hdl/psm_pkg.sv
// Types, signature table and compare helpers for the signature matcher.
`default_nettype none

package psm_pkg;

  localparam int TABLE_SLOTS = 16;
  localparam int TEXT_MAX    = 16;
  localparam int LEN_BITS    = 5;
  localparam int INDEX_BITS  = 3;

  typedef logic [7:0]            psm_byte_t;
  typedef logic [LEN_BITS-1:0]   sig_len_t;
  typedef logic [8*TEXT_MAX-1:0] sig_text_t;

  typedef struct packed {
    psm_byte_t payload_byte;
    logic      byte_present;
    logic      last_byte;
  } psm_in_t;

  typedef struct packed {
    logic                  matched;
    logic [INDEX_BITS-1:0] signature_index;
  } psm_out_t;

  // Signature lengths; unused slots are empty and never match.
  localparam sig_len_t SIG_LEN [TABLE_SLOTS] = '{
    0: 5'd11, 1: 5'd12, 2: 5'd8, 3: 5'd6, 4: 5'd10, 5: 5'd7, 6: 5'd8,
    default: 5'd0
  };

  // Signature text, right-justified: the first character sits in the
  // highest used byte.
  localparam sig_text_t SIG_TEXT [TABLE_SLOTS] = '{
    0: "' OR '1'='1",
    1: "UNION SELECT",
    2: "<script>",
    3: "../../",
    4: "etc/passwd",
    5: "cmd.exe",
    6: "; whoami",
    default: '0
  };

  // A signature takes part only if it is non-empty and fits the window.
  function automatic logic sig_enabled(input int slot, input int win_len);
    int len;
    len = int'(SIG_LEN[slot]);
    return (len != 0) && (len <= win_len);
  endfunction

  // True when window position pos agrees with the signature aligned to end
  // at the newest byte, or lies in front of the signature.
  function automatic logic sig_pos_ok(input int slot, input int pos, input int win_len,
                                      input psm_byte_t b);
    int   len;
    int   k;
    logic ok;
    len = int'(SIG_LEN[slot]);
    k   = pos - (win_len - len);
    ok  = 1'b1;
    if (k >= 0 && k < len) begin
      ok = (b == SIG_TEXT[slot][8*(len-1-k) +: 8]);
    end
    return ok;
  endfunction

endpackage

`default_nettype wire

FILE: hdl/psm_stream_if.sv
// Valid/ready stream channel carrying one typed payload.
`default_nettype none

interface psm_stream_if #(
  parameter type T = logic
);
  logic valid;
  logic ready;
  T     data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

`default_nettype wire

FILE: hdl/psm_cell.sv
// One window cell: holds a history byte and compares it with every signature.
`default_nettype none

module psm_cell
  import psm_pkg::*;
#(
  parameter int POS     = 0,
  parameter int WIN_LEN = 12,
  parameter int NUM_SIG = 7
) (
  input  logic               clk,
  input  logic               shift_en,
  input  psm_byte_t          byte_in,
  output psm_byte_t          byte_out,
  output logic [NUM_SIG-1:0] pos_ok
);

  psm_byte_t byte_r;

  // Advance the window by one byte when a byte is scanned.
  always_ff @(posedge clk) begin
    if (shift_en) begin
      byte_r <= byte_in;
    end
  end

  always_comb begin
    for (int i = 0; i < NUM_SIG; i++) begin
      pos_ok[i] = sig_pos_ok(i, POS, WIN_LEN, byte_r);
    end
  end

  assign byte_out = byte_r;

endmodule

`default_nettype wire

FILE: hdl/payload_signature_matcher.sv
// Every cell and the mask update together when a request's byte is scanned.
// Throughput: one request per cycle while ready is high.
// A finished result waits in the output register; one skid slot lets the next
// payload's final request through, and ready drops only while that slot is full.
// Reset (synchronous, active low) empties the output side, the byte count and the mask.
`default_nettype none

module payload_signature_matcher
  import psm_pkg::*;
#(
  parameter int NUM_SIGNATURES  = 7,
  parameter int MAX_PATTERN_LEN = 12
) (
  input  logic          clk,
  input  logic          rst_n,
  psm_stream_if.sink    in_stream,
  psm_stream_if.source  out_stream
);

`include "payload_signature_matcher_macros.svh"

  localparam int HIST_LEN = MAX_PATTERN_LEN - 1;
  localparam int CNT_BITS = $clog2(MAX_PATTERN_LEN + 1);

  // ---------------------------------------------------------------------------
  // Input request decode
  // ---------------------------------------------------------------------------
  psm_in_t item;
  logic    in_ready;
  logic    in_acc;
  logic    scan;
  logic    close;

  assign item   = in_stream.data;
  assign in_acc = in_stream.valid && in_ready;
  // Only a real byte advances the window; an item without a byte and without
  // the last flag does nothing at all.
  assign scan   = in_acc && item.byte_present;
  assign close  = in_acc && item.last_byte;

  // ---------------------------------------------------------------------------
  // Window: a row of cells holds the older bytes, the newest byte is the
  // incoming request itself. Window position HIST_LEN is the newest byte.
  // ---------------------------------------------------------------------------
  psm_byte_t                 cell_byte [HIST_LEN];
  logic [NUM_SIGNATURES-1:0] cell_ok   [HIST_LEN];

  for (genvar p = 0; p < HIST_LEN; p++) begin : g_cell
    psm_byte_t feed;
    if (p == HIST_LEN - 1) begin : g_head
      assign feed = item.payload_byte;
    end else begin : g_body
      assign feed = cell_byte[p+1];
    end

    psm_cell #(
      .POS     (p),
      .WIN_LEN (MAX_PATTERN_LEN),
      .NUM_SIG (NUM_SIGNATURES)
    ) u_cell (
      .clk      (clk),
      .shift_en (scan),
      .byte_in  (feed),
      .byte_out (cell_byte[p]),
      .pos_ok   (cell_ok[p])
    );
  end

  // ---------------------------------------------------------------------------
  // Byte count and match detection
  // ---------------------------------------------------------------------------
  logic [CNT_BITS-1:0]       bytes_seen_r;
  logic [CNT_BITS-1:0]       bytes_seen_nxt;
  logic [CNT_BITS-1:0]       seen_inc;
  logic [NUM_SIGNATURES-1:0] found_mask_r;
  logic [NUM_SIGNATURES-1:0] found_mask_nxt;
  logic [NUM_SIGNATURES-1:0] hit;
  logic [NUM_SIGNATURES-1:0] mask_cur;

  // Count saturates at the window length: enough to qualify every signature.
  assign seen_inc = (bytes_seen_r < CNT_BITS'(MAX_PATTERN_LEN)) ?
                    bytes_seen_r + CNT_BITS'(1) : bytes_seen_r;

  always_comb begin
    for (int i = 0; i < NUM_SIGNATURES; i++) begin
      // A signature counts only once the payload holds at least its length,
      // so bytes of an earlier payload never take part.
      hit[i] = sig_enabled(i, MAX_PATTERN_LEN) &&
               (int'(SIG_LEN[i]) <= int'(seen_inc)) &&
               sig_pos_ok(i, HIST_LEN, MAX_PATTERN_LEN, item.payload_byte);
      for (int p = 0; p < HIST_LEN; p++) begin
        hit[i] = hit[i] && cell_ok[p][i];
      end
    end
  end

  // Mask as it stands once this request's byte is scanned.
  assign mask_cur = scan ? (found_mask_r | hit) : found_mask_r;

  always_comb begin
    bytes_seen_nxt = bytes_seen_r;
    found_mask_nxt = found_mask_r;
    if (close) begin
      // Drop all payload state: the next payload starts clean.
      bytes_seen_nxt = '0;
      found_mask_nxt = '0;
    end else if (scan) begin
      bytes_seen_nxt = seen_inc;
      found_mask_nxt = mask_cur;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      bytes_seen_r <= '0;
      found_mask_r <= '0;
    end else begin
      bytes_seen_r <= bytes_seen_nxt;
      found_mask_r <= found_mask_nxt;
    end
  end

  // ---------------------------------------------------------------------------
  // Result: table priority, lowest index wins; index keeps its low bits.
  // ---------------------------------------------------------------------------
  psm_out_t res;

  always_comb begin
    res.matched         = |mask_cur;
    res.signature_index = '0;
    for (int i = NUM_SIGNATURES - 1; i >= 0; i--) begin
      if (mask_cur[i]) begin
        res.signature_index = INDEX_BITS'(i);
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Output register plus one skid slot
  // ---------------------------------------------------------------------------
  logic     out_valid_r;
  logic     out_valid_nxt;
  psm_out_t out_data_r;
  psm_out_t out_data_nxt;
  logic     skid_valid_r;
  logic     skid_valid_nxt;
  psm_out_t skid_data_r;
  psm_out_t skid_data_nxt;
  logic     out_free;

  // Ready comes from a register: the skid slot absorbs the one result that
  // may arrive while the output is stalled.
  assign in_ready = !skid_valid_r;
  assign out_free = !out_valid_r || out_stream.ready;

  always_comb begin
    out_valid_nxt  = out_valid_r;
    out_data_nxt   = out_data_r;
    skid_valid_nxt = skid_valid_r;
    skid_data_nxt  = skid_data_r;
    if (out_free) begin
      if (skid_valid_r) begin
        // Advance the waiting result; no new request is taken this cycle.
        out_valid_nxt  = 1'b1;
        out_data_nxt   = skid_data_r;
        skid_valid_nxt = 1'b0;
      end else begin
        out_valid_nxt = close;
        out_data_nxt  = res;
      end
    end else if (close) begin
      // Hold the new result aside while the output is stalled.
      skid_valid_nxt = 1'b1;
      skid_data_nxt  = res;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r  <= 1'b0;
      skid_valid_r <= 1'b0;
    end else begin
      out_valid_r  <= out_valid_nxt;
      skid_valid_r <= skid_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_data_r  <= out_data_nxt;
    skid_data_r <= skid_data_nxt;
  end

  assign in_stream.ready  = in_ready;
  assign out_stream.valid = out_valid_r;
  assign out_stream.data  = out_data_r;

  // ---------------------------------------------------------------------------
  // Assertions
  // ---------------------------------------------------------------------------
  `PSM_ASSERT(a_skid_behind_out, skid_valid_r |-> out_valid_r)
  `PSM_ASSERT(a_count_saturates, bytes_seen_r <= CNT_BITS'(MAX_PATTERN_LEN))
  `PSM_ASSERT_NEXT(a_close_clears, close, bytes_seen_r == '0 && found_mask_r == '0)
  `PSM_ASSERT(a_no_match_index, (out_valid_r && !out_data_r.matched) |-> out_data_r.signature_index == '0)

endmodule

`default_nettype wire

FILE: sim/tb.sv
// Self-checking testbench for payload_signature_matcher: scans random and directed payloads.

module tb
  import psm_pkg::*;
();

  localparam int SIG_COUNT   = 7;
  localparam int WIN_LEN     = 12;
  localparam int STALL_LIMIT = 2000;  // cycles with no request or result moving
  localparam int TAIL_CYCLES = 4;     // extra wait after the last verdict is delivered

  typedef enum logic [0:0] {SINK_ALWAYS, SINK_RANDOM} sink_mode_t;

  logic clk;
  logic rst_n;

  psm_stream_if #(.T(psm_in_t))  in_ch ();
  psm_stream_if #(.T(psm_out_t)) out_ch ();

  payload_signature_matcher i_dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_stream  (in_ch.sink),
    .out_stream (out_ch.source)
  );

  // Attack signatures in table priority order; index 0 wins over all others.
  string sig_text [SIG_COUNT] = '{
    "' OR '1'='1", "UNION SELECT", "<script>", "../../", "etc/passwd", "cmd.exe", "; whoami"
  };

  // Shadow of the scanner: sliding byte window, byte count and found mask.
  psm_byte_t              byte_hist [WIN_LEN-1];
  int                     bytes_seen;
  logic [SIG_COUNT-1:0]   found_mask;
  psm_out_t               pending_verdicts [$];

  // Shared stimulus state.
  psm_byte_t  body_q [$];       // bytes of the payload being built
  int         items_sent;       // requests that carry a byte or close a payload
  int         burst_left;
  int         src_max_gap;      // 0 runs the sender at full rate
  sink_mode_t sink_pattern;
  int         hold_off_cycles;  // nonzero asks the receiver for one long stall
  int         error_count;

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Drop the window and the mask so the next payload starts clean.
  function automatic void clear_scan_state();
    int k;
    for (k = 0; k < WIN_LEN - 1; k++) byte_hist[k] = '0;
    bytes_seen = 0;
    found_mask = '0;
  endfunction

  // Advance the shadow scanner by one accepted request; a closing request
  // queues the verdict for its payload.
  function automatic void scan_for_signatures(input psm_in_t r);
    psm_byte_t window [WIN_LEN];
    psm_out_t  verdict;
    int        s;
    int        k;
    int        len;
    logic      hit;
    if (r.byte_present) begin
      for (k = 0; k < WIN_LEN - 1; k++) window[k] = byte_hist[k];
      window[WIN_LEN-1] = r.payload_byte;
      if (bytes_seen < WIN_LEN) bytes_seen++;
      // Each signature is aligned to end at the newest byte.
      for (s = 0; s < SIG_COUNT; s++) begin
        len = sig_text[s].len();
        if (len <= bytes_seen) begin
          hit = 1'b1;
          for (k = 0; k < len; k++) begin
            if (window[WIN_LEN-len+k] != psm_byte_t'(sig_text[s][k])) hit = 1'b0;
          end
          if (hit) found_mask[s] = 1'b1;
        end
      end
      for (k = 0; k < WIN_LEN - 1; k++) byte_hist[k] = window[k+1];
    end
    if (r.last_byte) begin
      verdict = '0;
      // Walk down so the lowest set index is the one that stays.
      for (s = SIG_COUNT - 1; s >= 0; s--) begin
        if (found_mask[s]) begin
          verdict.matched         = 1'b1;
          verdict.signature_index = 3'(s);
        end
      end
      pending_verdicts.push_back(verdict);
      clear_scan_state();
    end
  endfunction

  // Offer one request and hold it until the block takes it. The sender runs
  // in bursts; a gap is never empty, so valid never drops and rises in the
  // same step.
  task automatic send_request(input psm_in_t r);
    if (src_max_gap > 0 && burst_left == 0) begin
      in_ch.valid <= 1'b0;
      repeat ($urandom_range(1, src_max_gap)) @(posedge clk);
      burst_left = $urandom_range(1, 24);
    end
    if (burst_left > 0) burst_left--;
    in_ch.valid <= 1'b1;
    in_ch.data  <= r;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
    scan_for_signatures(r);
    if (r.byte_present || r.last_byte) items_sent++;
  endtask

  // Send body_q as one payload. Either the last byte closes it, or a
  // byte-less terminator does; an empty body always takes the terminator.
  // Sprinkle byte-less, non-closing requests in between; the block drops them.
  task automatic send_payload(input bit with_terminator);
    psm_in_t r;
    int      i;
    for (i = 0; i < body_q.size(); i++) begin
      if ($urandom_range(0, 15) == 0) begin
        r.payload_byte = psm_byte_t'($urandom_range(0, 255));
        r.byte_present = 1'b0;
        r.last_byte    = 1'b0;
        send_request(r);
      end
      r.payload_byte = body_q[i];
      r.byte_present = 1'b1;
      r.last_byte    = !with_terminator && (i == body_q.size() - 1);
      send_request(r);
    end
    if (with_terminator || body_q.size() == 0) begin
      r.payload_byte = psm_byte_t'($urandom_range(0, 255));
      r.byte_present = 1'b0;
      r.last_byte    = 1'b1;
      send_request(r);
    end
  endtask

  task automatic load_text(input string s);
    int i;
    body_q = {};
    for (i = 0; i < s.len(); i++) body_q.push_back(psm_byte_t'(s[i]));
  endtask

  // Build a payload from fragments: whole signatures, truncated ones, ones
  // with a corrupted byte, raw noise and characters the signatures use.
  task automatic build_payload(input int max_frags);
    psm_byte_t b;
    int        s;
    int        len;
    int        pos;
    int        i;
    body_q = {};
    repeat ($urandom_range(0, max_frags)) begin
      s   = $urandom_range(0, SIG_COUNT - 1);
      len = sig_text[s].len();
      case ($urandom_range(0, 5))
        0, 1: begin
          for (i = 0; i < len; i++) body_q.push_back(psm_byte_t'(sig_text[s][i]));
        end
        2: begin
          pos = $urandom_range(1, len - 1);
          for (i = 0; i < pos; i++) body_q.push_back(psm_byte_t'(sig_text[s][i]));
        end
        3: begin
          pos = $urandom_range(0, len - 1);
          for (i = 0; i < len; i++) begin
            b = psm_byte_t'(sig_text[s][i]);
            if (i == pos) b ^= psm_byte_t'($urandom_range(1, 255));
            body_q.push_back(b);
          end
        end
        4: begin
          repeat ($urandom_range(1, 6)) body_q.push_back(psm_byte_t'($urandom_range(0, 255)));
        end
        default: begin
          repeat ($urandom_range(1, 4)) begin
            s = $urandom_range(0, SIG_COUNT - 1);
            body_q.push_back(psm_byte_t'(sig_text[s][$urandom_range(0, sig_text[s].len() - 1)]));
          end
        end
      endcase
    end
  endtask

  // Release the input and wait until every verdict has come back.
  task automatic finish_phase();
    in_ch.valid <= 1'b0;
    burst_left = 0;
    while (pending_verdicts.size() != 0) @(posedge clk);
    repeat (TAIL_CYCLES) @(posedge clk);
  endtask

  // Field extremes, dropped requests, empty payloads, a byte on the closing
  // request, a signature that exactly fills its payload, and one split over
  // two payloads, which must not match.
  task automatic run_directed_cases();
    psm_in_t r;
    src_max_gap  = 0;
    sink_pattern = SINK_ALWAYS;
    body_q = {};
    send_payload(1'b1);
    r.payload_byte = 8'hFF;
    r.byte_present = 1'b0;
    r.last_byte    = 1'b0;
    send_request(r);
    body_q = {8'h00, 8'hFF};
    send_payload(1'b0);
    load_text("../");
    send_payload(1'b0);
    load_text("../");
    send_payload(1'b0);
    load_text("../../");
    send_payload(1'b0);
    load_text("x");
    send_payload(1'b1);
    finish_phase();
  endtask

  // Back-to-back requests with the receiver always ready.
  task automatic run_full_rate(input int goal);
    src_max_gap  = 0;
    sink_pattern = SINK_ALWAYS;
    goal += items_sent;
    while (items_sent < goal) begin
      build_payload(4);
      send_payload($urandom_range(0, 3) == 0);
    end
    finish_phase();
  endtask

  // Well-formed payloads with random content, gaps on both sides.
  task automatic run_random_payloads(input int goal);
    src_max_gap  = 6;
    sink_pattern = SINK_RANDOM;
    goal += items_sent;
    while (items_sent < goal) begin
      build_payload($urandom_range(0, 6));
      send_payload($urandom_range(0, 3) == 0);
    end
    finish_phase();
  endtask

  // Hold the receiver off for a long stretch while short payloads keep
  // coming, so finished verdicts back up and the block stalls its input.
  task automatic run_backpressure(input int goal);
    src_max_gap     = 0;
    sink_pattern    = SINK_RANDOM;
    hold_off_cycles = 400;
    goal += items_sent;
    while (items_sent < goal) begin
      body_q = {};
      repeat ($urandom_range(0, 3)) body_q.push_back(psm_byte_t'($urandom_range(0, 255)));
      send_payload($urandom_range(0, 2) == 0);
    end
    finish_phase();
  endtask

  // Receiver pacing: one long hold-off on request, else always ready or
  // alternating random ready and stall runs.
  initial begin : sink_pacing
    int run;
    out_ch.ready <= 1'b0;
    wait (rst_n === 1'b1);
    @(posedge clk);
    forever begin
      if (hold_off_cycles > 0) begin
        out_ch.ready <= 1'b0;
        repeat (hold_off_cycles) @(posedge clk);
        hold_off_cycles = 0;
      end else if (sink_pattern == SINK_ALWAYS) begin
        out_ch.ready <= 1'b1;
        @(posedge clk);
      end else begin
        run = $urandom_range(1, 8);
        out_ch.ready <= 1'b1;
        repeat (run) @(posedge clk);
        run = $urandom_range(1, 5);
        out_ch.ready <= 1'b0;
        repeat (run) @(posedge clk);
      end
    end
  end

  // Compare every delivered verdict with the oldest one waiting.
  always @(posedge clk) begin : verdict_check
    psm_out_t want;
    if (rst_n && out_ch.valid && out_ch.ready) begin
      if (pending_verdicts.size() == 0) begin
        $display("%0t: unexpected result matched=%0b index=%0d", $time,
                 out_ch.data.matched, out_ch.data.signature_index);
        error_count++;
      end else begin
        want = pending_verdicts.pop_front();
        if (out_ch.data.matched !== want.matched) begin
          $display("%0t: matched expected %0b actual %0b", $time,
                   want.matched, out_ch.data.matched);
          error_count++;
        end
        if (out_ch.data.signature_index !== want.signature_index) begin
          $display("%0t: signature_index expected %0d actual %0d", $time,
                   want.signature_index, out_ch.data.signature_index);
          error_count++;
        end
      end
    end
  end

  // End the run if neither a request nor a result moves for too long.
  initial begin : watchdog
    int idle;
    idle = 0;
    while (idle < STALL_LIMIT) begin
      @(posedge clk);
      if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) idle = 0;
      else idle++;
    end
    $display("timeout: no progress for %0d cycles", STALL_LIMIT);
    $display("== FAIL ==");
    $finish;
  end

  initial begin
    rst_n           <= 1'b0;
    in_ch.valid     <= 1'b0;
    in_ch.data      <= '0;
    items_sent      = 0;
    burst_left      = 0;
    src_max_gap     = 0;
    sink_pattern    = SINK_ALWAYS;
    hold_off_cycles = 0;
    error_count     = 0;
    clear_scan_state();
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    run_directed_cases();
    run_full_rate(300);
    run_random_payloads(700);
    run_backpressure(180);
    run_random_payloads(150);

    if (error_count == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule

FILE: filelist.f
+incdir+hdl
hdl/psm_pkg.sv
hdl/psm_stream_if.sv
hdl/psm_cell.sv
hdl/payload_signature_matcher.sv
sim/tb.sv
